### rtl/gjs_pkg.sv
package gjs_pkg;

  localparam int unsigned MaxOrder   = 64;
  localparam int unsigned OrderW     = 7;
  localparam int unsigned FloorW     = 17;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned CfgIndexW  = 1;

  localparam logic [CfgIndexW-1:0] RegMatrixOrder = 1'd0;
  localparam logic [CfgIndexW-1:0] RegPivotFloor  = 1'd1;

  localparam int unsigned OrderReset = 1;
  localparam int unsigned FloorReset = 1;

  typedef struct packed {
    logic start;
    logic [ValueW-1:0] dividend;
    logic [ValueW-1:0] divisor;
  } div_req_t;

  function automatic logic [ValueW-1:0] sat32(input logic signed [ValueW+32:0] v);
    logic signed [ValueW+32:0] hi;
    logic signed [ValueW+32:0] lo;
    hi = (ValueW+33)'(signed'({1'b0, {(ValueW-1){1'b1}}}));
    lo = -hi - (ValueW+33)'(1);
    if (v > hi) begin
      return {1'b0, {(ValueW-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(ValueW-1){1'b0}}};
    end
    return v[ValueW-1:0];
  endfunction

endpackage

### rtl/gjs_if.sv
interface gjs_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] row_index;
  logic [6:0] col_index;
  logic signed [31:0] entry_value;
  logic       start_solve;
  modport source (output valid, row_index, col_index, entry_value, start_solve,
                  input ready);
  modport sink (input valid, row_index, col_index, entry_value, start_solve,
                output ready);
endinterface

interface gjs_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] unknown_index;
  logic signed [31:0] solution_value;
  logic       singular;
  logic       last_result;
  modport source (output valid, unknown_index, solution_value, singular, last_result,
                  input ready);
  modport sink (input valid, unknown_index, solution_value, singular, last_result,
                output ready);
endinterface

interface gjs_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/gauss_jordan_solver_unit.sv
// Gauss-Jordan solver without row exchange, signed Q16.16.
// Configuration words set the order n (index 0) and the pivot floor (index 1);
// they must be written only while the block is idle; the block does not enforce this.
// Each input word loads one entry of the augmented matrix (column MaxOrder is
// the right-hand side) into a single-port-write memory; loading takes one cycle
// per word. A word with start_solve set stores its entry and then starts the
// solve, during which no input word is accepted.
// For each pivot row the row is normalised through a 48-step serial divider,
// then each other row is updated with two reads, a multiply and a write-back
// per entry. A failing pivot ends the solve early. Results follow one word at
// a time, each after the last is taken: n solution words in row order, or one
// singular word naming the failing pivot row.
// Each result waits in an output register until taken; a stalled receiver
// simply holds the block in its emit phase.
// Reset returns the registers to n = 1 and floor = 1; matrix contents are
// undefined until written.
module gauss_jordan_solver_unit #(
  parameter int unsigned MaxOrder = gjs_pkg::MaxOrder
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  gjs_in_if.sink   in_if,
  gjs_out_if.source out_if,
  gjs_cfg_if.sink  cfg_if
);

  localparam int unsigned RowLen = MaxOrder + 1;
  localparam int unsigned Depth  = MaxOrder * RowLen;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned IdxW   = $clog2(RowLen);
  localparam int unsigned VW     = gjs_pkg::ValueW;

  localparam logic [3:0] StLoad   = 4'd0;
  localparam logic [3:0] StPivRd  = 4'd1;
  localparam logic [3:0] StPivChk = 4'd2;
  localparam logic [3:0] StNrmRd  = 4'd3;
  localparam logic [3:0] StNrmDiv = 4'd4;
  localparam logic [3:0] StNrmWt  = 4'd5;
  localparam logic [3:0] StFacRd  = 4'd6;
  localparam logic [3:0] StFacGet = 4'd7;
  localparam logic [3:0] StUpdP   = 4'd8;
  localparam logic [3:0] StUpdK   = 4'd9;
  localparam logic [3:0] StUpdMul = 4'd10;
  localparam logic [3:0] StUpdWr  = 4'd11;
  localparam logic [3:0] StOutRd  = 4'd12;
  localparam logic [3:0] StOutWt  = 4'd13;
  localparam logic [3:0] StOut    = 4'd14;

  logic [3:0]  st_q, st_d;
  logic [gjs_pkg::OrderW-1:0] order_q;
  logic [gjs_pkg::FloorW-1:0] floor_q;
  logic [IdxW-1:0] n_eff;
  logic [IdxW-1:0] i_q, i_d, k_q, k_d, j_q, j_d;
  logic [VW-1:0] piv_q, piv_d, fac_q, fac_d, pv_q, pv_d;
  logic signed [2*VW-1:0] prod_q, prod_d;
  logic [VW-1:0] out_val_q, out_val_d;
  logic [IdxW-1:0] out_idx_q, out_idx_d;
  logic out_sing_q, out_sing_d, out_last_q, out_last_d, out_vld_q, out_vld_d;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rdata;
  gjs_pkg::div_req_t dreq;
  logic ddone;
  logic [VW-1:0] dquot;
  logic [VW:0] piv_mag;
  logic [IdxW-1:0] jcol;
  logic signed [VW+32:0] diff;

  always_comb begin
    if (order_q == '0) begin
      n_eff = IdxW'(1);
    end else if (32'(order_q) > MaxOrder) begin
      n_eff = IdxW'(MaxOrder);
    end else begin
      n_eff = IdxW'(order_q);
    end
  end

  function automatic logic [AddrW-1:0] addr(input logic [IdxW-1:0] r,
                                            input logic [IdxW-1:0] c);
    return AddrW'(32'(r) * RowLen + 32'(c));
  endfunction

  // Column order of a row pass: columns i..n-1, then the right-hand side.
  assign jcol = (j_q == n_eff) ? IdxW'(MaxOrder) : j_q;
  assign piv_mag = rdata[VW-1] ? {1'b0, -rdata} : {1'b0, rdata};
  assign diff = $signed({{33{rdata[VW-1]}}, rdata})
              - $signed({{(VW+33-2*VW+16){prod_q[2*VW-1]}}, prod_q[2*VW-1:16]});

  gjs_ram #(.Width(VW), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  gjs_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dquot));

  assign in_if.ready  = (st_q == StLoad);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_vld_q;
  assign out_if.unknown_index  = out_idx_q[5:0];
  assign out_if.solution_value = out_val_q;
  assign out_if.singular    = out_sing_q;
  assign out_if.last_result = out_last_q;

  always_comb begin
    st_d = st_q; i_d = i_q; k_d = k_q; j_d = j_q;
    piv_d = piv_q; fac_d = fac_q; pv_d = pv_q; prod_d = prod_q;
    out_val_d = out_val_q; out_idx_d = out_idx_q; out_sing_d = out_sing_q;
    out_last_d = out_last_q; out_vld_d = out_vld_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    dreq = '0;
    if (out_vld_q && out_if.ready) begin
      out_vld_d = 1'b0;
    end
    case (st_q)
      StLoad: begin
        if (in_if.valid) begin
          if (32'(in_if.row_index) < MaxOrder && 32'(in_if.col_index) <= MaxOrder) begin
            we = 1'b1;
            waddr = addr(IdxW'(in_if.row_index), IdxW'(in_if.col_index));
            wdata = in_if.entry_value;
          end
          if (in_if.start_solve) begin
            i_d = '0;
            st_d = StPivRd;
          end
        end
      end
      StPivRd: begin
        raddr = addr(i_q, i_q);
        st_d = StPivChk;
      end
      StPivChk: begin
        piv_d = rdata;
        st_d = StNrmRd;
        j_d = i_q;
        if (rdata == '0 || piv_mag < (VW+1)'(floor_q)) begin
          if (!out_vld_q) begin
            out_vld_d = 1'b1; out_idx_d = i_q; out_val_d = '0;
            out_sing_d = 1'b1; out_last_d = 1'b1;
            st_d = StLoad;
          end else begin
            st_d = StPivChk;
            raddr = addr(i_q, i_q);
          end
        end
      end
      StNrmRd: begin
        raddr = addr(i_q, jcol);
        st_d = StNrmDiv;
      end
      StNrmDiv: begin
        dreq.start = 1'b1;
        dreq.dividend = rdata;
        dreq.divisor = piv_q;
        st_d = StNrmWt;
      end
      StNrmWt: begin
        if (ddone) begin
          we = 1'b1; waddr = addr(i_q, jcol); wdata = dquot;
          if (j_q == n_eff) begin
            k_d = '0;
            st_d = StFacRd;
          end else begin
            j_d = j_q + IdxW'(1);
            st_d = StNrmRd;
          end
        end
      end
      StFacRd: begin
        if (k_q == n_eff) begin
          i_d = i_q + IdxW'(1);
          st_d = (i_q + IdxW'(1) == n_eff) ? StOutRd : StPivRd;
          k_d = '0;
        end else if (k_q == i_q) begin
          k_d = k_q + IdxW'(1);
        end else begin
          raddr = addr(k_q, i_q);
          st_d = StFacGet;
        end
      end
      StFacGet: begin
        fac_d = rdata;
        j_d = i_q;
        st_d = StUpdP;
      end
      StUpdP: begin
        raddr = addr(i_q, jcol);
        st_d = StUpdK;
      end
      StUpdK: begin
        pv_d = rdata;
        raddr = addr(k_q, jcol);
        st_d = StUpdMul;
      end
      StUpdMul: begin
        prod_d = $signed(fac_q) * $signed(pv_q);
        raddr = addr(k_q, jcol);
        st_d = StUpdWr;
      end
      StUpdWr: begin
        we = 1'b1; waddr = addr(k_q, jcol); wdata = gjs_pkg::sat32(diff);
        if (j_q == n_eff) begin
          k_d = k_q + IdxW'(1);
          st_d = StFacRd;
        end else begin
          j_d = j_q + IdxW'(1);
          st_d = StUpdP;
        end
      end
      StOutRd: begin
        raddr = addr(k_q, IdxW'(MaxOrder));
        st_d = StOutWt;
      end
      StOutWt: begin
        raddr = addr(k_q, IdxW'(MaxOrder));
        st_d = StOut;
      end
      StOut: begin
        raddr = addr(k_q, IdxW'(MaxOrder));
        if (!out_vld_q) begin
          out_vld_d = 1'b1; out_idx_d = k_q; out_val_d = rdata;
          out_sing_d = 1'b0; out_last_d = (k_q + IdxW'(1) == n_eff);
          if (k_q + IdxW'(1) == n_eff) begin
            st_d = StLoad;
          end else begin
            k_d = k_q + IdxW'(1);
            st_d = StOutRd;
          end
        end
      end
      default: st_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad;
      out_vld_q <= 1'b0;
      order_q <= gjs_pkg::OrderW'(gjs_pkg::OrderReset);
      floor_q <= gjs_pkg::FloorW'(gjs_pkg::FloorReset);
      i_q <= '0; k_q <= '0; j_q <= '0;
    end else begin
      st_q <= st_d;
      out_vld_q <= out_vld_d;
      i_q <= i_d; k_q <= k_d; j_q <= j_d;
      if (cfg_if.valid) begin
        case (cfg_if.index)
          gjs_pkg::RegMatrixOrder: order_q <= cfg_if.data[gjs_pkg::OrderW-1:0];
          gjs_pkg::RegPivotFloor:  floor_q <= cfg_if.data[gjs_pkg::FloorW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    piv_q <= piv_d; fac_q <= fac_d; pv_q <= pv_d; prod_q <= prod_d;
    out_val_q <= out_val_d; out_idx_q <= out_idx_d;
    out_sing_q <= out_sing_d; out_last_q <= out_last_d;
  end

endmodule

### rtl/gjs_ram.sv
module gjs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4160
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/gjs_div.sv
// Radix-2 restoring divider: q = sat((a << 16) / p), truncated toward zero.
module gjs_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  gjs_pkg::div_req_t        req_i,
  output logic                     done_o,
  output logic [gjs_pkg::ValueW-1:0] quot_o
);

  localparam int unsigned NumW = gjs_pkg::ValueW + gjs_pkg::FracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]    num_q, num_d;
  logic [NumW-1:0]    quo_q, quo_d;
  logic [gjs_pkg::ValueW:0] rem_q, rem_d;
  logic [gjs_pkg::ValueW-1:0] den_q, den_d;
  logic               neg_q, neg_d;
  logic               busy_q, busy_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [gjs_pkg::ValueW-1:0] res_q, res_d;
  logic [gjs_pkg::ValueW:0] trial;
  logic [gjs_pkg::ValueW-1:0] a_mag, p_mag;
  logic signed [gjs_pkg::ValueW+32:0] signed_q;

  assign a_mag = req_i.dividend[gjs_pkg::ValueW-1] ? -req_i.dividend : req_i.dividend;
  assign p_mag = req_i.divisor[gjs_pkg::ValueW-1] ? -req_i.divisor : req_i.divisor;
  assign trial = {rem_q[gjs_pkg::ValueW-1:0], num_q[NumW-1]};

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    res_d  = res_q;
    signed_q = '0;
    if (req_i.start) begin
      num_d  = {a_mag, {gjs_pkg::FracBits{1'b0}}};
      quo_d  = '0;
      rem_d  = '0;
      den_d  = p_mag;
      neg_d  = req_i.dividend[gjs_pkg::ValueW-1] ^ req_i.divisor[gjs_pkg::ValueW-1];
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        signed_q = neg_q ? -($signed({17'b0, quo_d})) : $signed({17'b0, quo_d});
        res_d = gjs_pkg::sat32(signed_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign quot_o = res_q;

endmodule
